@@ src/button_debounce_hold_detect_macros.svh @@
// Assertion macros shared by the button debounce and hold detect block.
`ifndef BUTTON_DEBOUNCE_HOLD_DETECT_MACROS_SVH
`define BUTTON_DEBOUNCE_HOLD_DETECT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define BDHD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bdhd assertion failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define BDHD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bdhd assertion failed");

`endif

@@ src/bdhd_pkg.sv @@
// Shared types and constants of the button debounce and hold detect block.
package bdhd_pkg;

	localparam int DEF_TIME_WIDTH = 48;
	localparam int DEBOUNCE_W     = 24;
	localparam int HOLD_W         = 32;
	localparam int CFG_DATA_W     = 32;
	localparam int CFG_IDX_W      = 2;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 24'd20000;
	localparam logic [HOLD_W-1:0]     HOLD_RESET     = 32'd500000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_HOLD     = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic is_down;
		logic press_event;
		logic release_event;
		logic hold_event;
	} result_t;

	typedef struct packed {
		logic ack_press;
		logic ack_release;
		logic ack_hold;
	} ack_t;

endpackage

@@ src/button_debounce_hold_detect.sv @@
// Top level of the button debounce and hold detect block.
// Each request carries one timestamped raw button sample and three acknowledge bits and
// yields exactly one result with the debounced level and the sticky press, release and
// hold flags. A request is taken into an input register, the whole state update runs in
// one pass of logic to the result register, and a new request can be accepted every
// clock cycle unless a stalled result blocks the input register. The result register
// lets a new request enter while an earlier result still waits downstream. The first
// sample after reset adopts its level as stable. Timestamps and elapsed times wrap
// modulo 2^TIME_WIDTH. Configuration writes take effect on the following cycle.
`include "button_debounce_hold_detect_macros.svh"

module button_debounce_hold_detect #(
	parameter int TIME_WIDTH = bdhd_pkg::DEF_TIME_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [bdhd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bdhd_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            raw_level,
	input  logic [TIME_WIDTH-1:0]           sample_time,
	input  logic                            ack_press,
	input  logic                            ack_release,
	input  logic                            ack_hold,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            is_down,
	output logic                            press_event,
	output logic                            release_event,
	output logic                            hold_event
);
	import bdhd_pkg::*;

	logic [DEBOUNCE_W-1:0] debounce_q;
	logic [HOLD_W-1:0]     hold_q;

	logic                  valid_s1;
	logic                  raw_level_s1;
	logic [TIME_WIDTH-1:0] sample_time_s1;
	ack_t                  ack_s1;

	logic                  out_valid_q;
	result_t               res_q;
	result_t               res_n;
	logic                  advance;
	logic                  take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			hold_q     <= HOLD_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_DEBOUNCE: debounce_q <= cfg_wr_data[DEBOUNCE_W-1:0];
				REG_HOLD:     hold_q     <= cfg_wr_data[HOLD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			raw_level_s1   <= raw_level;
			sample_time_s1 <= sample_time;
			ack_s1         <= '{ack_press: ack_press, ack_release: ack_release,
				ack_hold: ack_hold};
		end
	end

	bdhd_core #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.raw_level    (raw_level_s1),
		.sample_time  (sample_time_s1),
		.ack          (ack_s1),
		.debounce_time(debounce_q),
		.hold_time    (hold_q),
		.result       (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign is_down       = res_q.is_down;
	assign press_event   = res_q.press_event;
	assign release_event = res_q.release_event;
	assign hold_event    = res_q.hold_event;

	`BDHD_ASSERT_IMPL(a_stall_needs_full_s1, in_stall, valid_s1)
	`BDHD_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_q)
	`BDHD_ASSERT_NEXT(a_blocked_s1_holds, valid_s1 && !advance,
		valid_s1 && $stable(sample_time_s1) && $stable(raw_level_s1))

endmodule

@@ src/bdhd_core.sv @@
// Debounce and hold state with its single-pass next-state logic.
module bdhd_core #(
	parameter int TIME_WIDTH = bdhd_pkg::DEF_TIME_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic                            raw_level,
	input  logic [TIME_WIDTH-1:0]           sample_time,
	input  bdhd_pkg::ack_t                  ack,
	input  logic [bdhd_pkg::DEBOUNCE_W-1:0] debounce_time,
	input  logic [bdhd_pkg::HOLD_W-1:0]     hold_time,
	output bdhd_pkg::result_t               result
);
	import bdhd_pkg::*;

	localparam int DB_CMP_W   = (TIME_WIDTH > DEBOUNCE_W) ? TIME_WIDTH : DEBOUNCE_W;
	localparam int HOLD_CMP_W = (TIME_WIDTH > HOLD_W) ? TIME_WIDTH : HOLD_W;

	logic                  stable_q, cand_q, primed_q, hold_done_q;
	logic                  press_latch_q, release_latch_q, hold_latch_q;
	logic [TIME_WIDTH-1:0] cand_start_q, press_start_q;

	logic                  stable_n, cand_n, hold_done_n, hold_done_mid;
	logic                  press_n, release_n, hold_n;
	logic [TIME_WIDTH-1:0] cand_start_n, press_start_n;
	logic [TIME_WIDTH-1:0] el_cand, el_press;
	logic                  hold_reached, debounce_reached;

	assign el_cand  = sample_time - cand_start_q;
	assign el_press = sample_time - press_start_q;

	assign hold_reached     = HOLD_CMP_W'(el_press) >= HOLD_CMP_W'(hold_time);
	assign debounce_reached = DB_CMP_W'(el_cand) >= DB_CMP_W'(debounce_time);

	always_comb begin
		stable_n      = stable_q;
		cand_n        = cand_q;
		cand_start_n  = cand_start_q;
		press_start_n = press_start_q;
		hold_done_mid = hold_done_q;
		hold_done_n   = hold_done_q;
		press_n       = press_latch_q;
		release_n     = release_latch_q;
		hold_n        = hold_latch_q;
		if (!primed_q) begin
			stable_n      = raw_level;
			cand_n        = raw_level;
			cand_start_n  = sample_time;
			press_start_n = sample_time;
			hold_done_n   = raw_level;
		end else begin
			if (stable_q && !hold_done_q && hold_reached) begin
				hold_n        = 1'b1;
				hold_done_mid = 1'b1;
			end
			hold_done_n = hold_done_mid;
			if (raw_level != cand_q) begin
				cand_n       = raw_level;
				cand_start_n = sample_time;
			end else if (cand_q != stable_q && debounce_reached) begin
				stable_n = cand_q;
				if (cand_q) begin
					press_n       = 1'b1;
					press_start_n = sample_time;
					hold_done_n   = 1'b0;
				end else if (!hold_done_mid) begin
					release_n = 1'b1;
				end
			end
		end
	end

	assign result = '{is_down: stable_n, press_event: press_n,
		release_event: release_n, hold_event: hold_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q        <= 1'b0;
			cand_q          <= 1'b0;
			cand_start_q    <= '0;
			primed_q        <= 1'b0;
			press_start_q   <= '0;
			hold_done_q     <= 1'b0;
			press_latch_q   <= 1'b0;
			release_latch_q <= 1'b0;
			hold_latch_q    <= 1'b0;
		end else if (step) begin
			stable_q        <= stable_n;
			cand_q          <= cand_n;
			cand_start_q    <= cand_start_n;
			primed_q        <= 1'b1;
			press_start_q   <= press_start_n;
			hold_done_q     <= hold_done_n;
			press_latch_q   <= press_n & ~ack.ack_press;
			release_latch_q <= release_n & ~ack.ack_release;
			hold_latch_q    <= hold_n & ~ack.ack_hold;
		end
	end

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the button debounce and hold detect block.
`timescale 1ns / 1ps

module tb_top;
	import bdhd_pkg::*;

	localparam int TW = DEF_TIME_WIDTH;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_SHOWN = 10;
	localparam int ROW_COUNT = 24;
	localparam int ZERO_ROW = 20;
	localparam int PHASE_COUNT = 6;
	localparam int PHASE_ITEMS = 75;
	localparam int LONG_HOLD_AT = 200;
	localparam int LONG_HOLD_CYCLES = 80;
	localparam int DRAIN_TAIL = 8;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic          lvl;
		logic [TW-1:0] stamp;
		ack_t          ack;
	} sample_t;

	typedef struct packed {
		sample_t smp;
		logic    fixed;
		result_t want;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_DEBOUNCE;
	logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  raw_level = 1'b0;
	logic [TW-1:0]         sample_time = '0;
	logic                  ack_press = 1'b0;
	logic                  ack_release = 1'b0;
	logic                  ack_hold = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  is_down;
	logic                  press_event;
	logic                  release_event;
	logic                  hold_event;

	// Predictor copy of the thresholds and the debounce state.
	logic [DEBOUNCE_W-1:0] settle_us;
	logic [HOLD_W-1:0]     hold_us;
	logic                  st_level;
	logic                  cand_level;
	logic                  primed;
	logic                  hold_done;
	logic                  press_f;
	logic                  release_f;
	logic                  hold_f;
	logic [TW-1:0]         cand_t;
	logic [TW-1:0]         press_t;

	result_t awaited_reports[$];
	int      reports_seen = 0;
	int      samples_sent = 0;
	int      mismatches = 0;
	int      cycle_count = 0;
	int      send_run = 0;
	int      sink_run = 0;

	button_debounce_hold_detect u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.raw_level    (raw_level),
		.sample_time  (sample_time),
		.ack_press    (ack_press),
		.ack_release  (ack_release),
		.ack_hold     (ack_hold),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.is_down      (is_down),
		.press_event  (press_event),
		.release_event(release_event),
		.hold_event   (hold_event)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding.", cycle_count,
				awaited_reports.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic int idle_draw(inout int run);
		if (run > 0) begin
			run--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			run = $urandom_range(10, 30);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	function automatic result_t debounce_step(input sample_t s);
		result_t       r;
		logic [TW-1:0] held;
		logic [TW-1:0] settled;
		held = s.stamp - press_t;
		settled = s.stamp - cand_t;
		if (!primed) begin
			st_level = s.lvl;
			cand_level = s.lvl;
			cand_t = s.stamp;
			press_t = s.stamp;
			primed = 1'b1;
			hold_done = s.lvl;
		end else begin
			if (st_level && !hold_done && held >= hold_us) begin
				hold_f = 1'b1;
				hold_done = 1'b1;
			end
			if (s.lvl != cand_level) begin
				cand_level = s.lvl;
				cand_t = s.stamp;
			end else if (cand_level != st_level && settled >= settle_us) begin
				st_level = cand_level;
				if (st_level) begin
					press_f = 1'b1;
					press_t = s.stamp;
					hold_done = 1'b0;
				end else if (!hold_done) begin
					release_f = 1'b1;
				end
			end
		end
		r.is_down = st_level;
		r.press_event = press_f;
		r.release_event = release_f;
		r.hold_event = hold_f;
		if (s.ack.ack_press)
			press_f = 1'b0;
		if (s.ack.ack_release)
			release_f = 1'b0;
		if (s.ack.ack_hold)
			hold_f = 1'b0;
		return r;
	endfunction

	function automatic row_t mk_row(input logic lvl, input logic [TW-1:0] stamp,
			input logic [2:0] acks, input logic fixed, input logic [3:0] want);
		row_t r;
		r.smp.lvl = lvl;
		r.smp.stamp = stamp;
		r.smp.ack = acks;
		r.fixed = fixed;
		r.want = want;
		return r;
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= data;
		if (idx == REG_DEBOUNCE)
			settle_us = data[DEBOUNCE_W-1:0];
		else if (idx == REG_HOLD)
			hold_us = data[HOLD_W-1:0];
	endtask

	task automatic drain_reports();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
	endtask

	// Writes to the unused indexes come last so that a decode error cannot hide.
	task automatic apply_settings(input logic [CFG_DATA_W-1:0] dbnc_data,
			input logic [CFG_DATA_W-1:0] hold_data);
		drain_reports();
		cfg_write(REG_DEBOUNCE, dbnc_data);
		cfg_write(REG_HOLD, hold_data);
		cfg_write(REG_SPARE_A, $urandom);
		cfg_write(REG_SPARE_B, $urandom);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic offer_sample(input sample_t s, input logic fixed, input result_t want);
		int      gap;
		result_t predicted;
		gap = idle_draw(send_run);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		raw_level <= s.lvl;
		sample_time <= s.stamp;
		ack_press <= s.ack.ack_press;
		ack_release <= s.ack.ack_release;
		ack_hold <= s.ack.ack_hold;
		do @(posedge clk); while (in_stall);
		predicted = debounce_step(s);
		awaited_reports.push_back(fixed ? want : predicted);
		samples_sent++;
	endtask

	initial begin : report_sink
		int      stall_n;
		logic    long_done;
		result_t want;
		result_t got;
		long_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall_n = idle_draw(sink_run);
			if (!long_done && reports_seen >= LONG_HOLD_AT) begin
				stall_n = LONG_HOLD_CYCLES;
				long_done = 1'b1;
			end
			@(negedge clk);
			if (stall_n > 0) begin
				out_stall <= 1'b1;
				repeat (stall_n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			got = {is_down, press_event, release_event, hold_event};
			reports_seen++;
			if (awaited_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("%0t: unexpected result %b", $realtime, got);
			end else begin
				want = awaited_reports.pop_front();
				if (got.is_down !== want.is_down || got.press_event !== want.press_event ||
						got.release_event !== want.release_event ||
						got.hold_event !== want.hold_event) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("%0t: result %0d down %b/%b press %b/%b release %b/%b hold %b/%b (exp/act)",
							$realtime, reports_seen, want.is_down, got.is_down,
							want.press_event, got.press_event, want.release_event,
							got.release_event, want.hold_event, got.hold_event);
				end
			end
		end
	end

	initial begin : stimulus
		row_t                  rows [ROW_COUNT];
		sample_t               s;
		logic [TW-1:0]         stamp;
		logic [63:0]           wide;
		logic [CFG_DATA_W-1:0] dbnc_data;
		logic [CFG_DATA_W-1:0] hold_data;
		logic                  want_lvl;
		int unsigned           step;
		int                    pick;
		int                    ph;
		int                    k;

		settle_us = DEBOUNCE_RESET;
		hold_us = HOLD_RESET;
		st_level = 1'b0;
		cand_level = 1'b0;
		primed = 1'b0;
		hold_done = 1'b0;
		press_f = 1'b0;
		release_f = 1'b0;
		hold_f = 1'b0;
		cand_t = '0;
		press_t = '0;

		rows[0] = mk_row(1'b1, 48'd100, 3'b111, 1'b1, 4'b1000);
		rows[1] = mk_row(1'b1, 48'd600100, 3'b000, 1'b0, 4'b0000);
		rows[2] = mk_row(1'b0, 48'd600200, 3'b000, 1'b0, 4'b0000);
		rows[3] = mk_row(1'b0, 48'd620199, 3'b000, 1'b0, 4'b0000);
		rows[4] = mk_row(1'b0, 48'd620200, 3'b000, 1'b1, 4'b0000);
		rows[5] = mk_row(1'b1, 48'd630000, 3'b000, 1'b0, 4'b0000);
		rows[6] = mk_row(1'b0, 48'd630005, 3'b000, 1'b0, 4'b0000);
		rows[7] = mk_row(1'b1, 48'd630010, 3'b000, 1'b0, 4'b0000);
		rows[8] = mk_row(1'b1, 48'd650010, 3'b000, 1'b0, 4'b0000);
		rows[9] = mk_row(1'b0, 48'd655000, 3'b000, 1'b0, 4'b0000);
		rows[10] = mk_row(1'b0, 48'd675000, 3'b110, 1'b0, 4'b0000);
		rows[11] = mk_row(1'b1, 48'd680000, 3'b000, 1'b0, 4'b0000);
		rows[12] = mk_row(1'b1, 48'd700000, 3'b000, 1'b0, 4'b0000);
		rows[13] = mk_row(1'b1, 48'd1200000, 3'b000, 1'b0, 4'b0000);
		rows[14] = mk_row(1'b0, 48'd1200001, 3'b000, 1'b0, 4'b0000);
		rows[15] = mk_row(1'b0, 48'd1220001, 3'b111, 1'b0, 4'b0000);
		rows[16] = mk_row(1'b1, 48'hFFFF_FFFF_D8F0, 3'b000, 1'b0, 4'b0000);
		rows[17] = mk_row(1'b1, 48'd10000, 3'b000, 1'b0, 4'b0000);
		rows[18] = mk_row(1'b1, 48'd5000, 3'b000, 1'b0, 4'b0000);
		rows[19] = mk_row(1'b0, 48'hFFFF_FFFF_FFFF, 3'b111, 1'b0, 4'b0000);
		rows[20] = mk_row(1'b0, 48'd0, 3'b000, 1'b0, 4'b0000);
		rows[21] = mk_row(1'b1, 48'd0, 3'b000, 1'b0, 4'b0000);
		rows[22] = mk_row(1'b1, 48'd0, 3'b000, 1'b0, 4'b0000);
		rows[23] = mk_row(1'b1, 48'd0, 3'b111, 1'b0, 4'b0000);

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < ROW_COUNT; k++) begin
			if (k == ZERO_ROW)
				apply_settings('0, '0);
			offer_sample(rows[k].smp, rows[k].fixed, rows[k].want);
		end

		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: begin
					dbnc_data = $urandom & 32'hFF00_0000;
					hold_data = '0;
				end
				1: begin
					dbnc_data = '1;
					hold_data = '1;
				end
				default: begin
					dbnc_data = ($urandom & 32'hFF00_0000) | $urandom_range(1, 60);
					hold_data = $urandom_range(1, 400);
				end
			endcase
			apply_settings(dbnc_data, hold_data);
			wide = {$urandom, $urandom};
			stamp = wide[TW-1:0];
			want_lvl = $urandom_range(0, 1);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == 3 && k == PHASE_ITEMS / 2)
					drain_reports();
				if ($urandom_range(0, 9) == 0)
					want_lvl = !want_lvl;
				step = settle_us / 3 + 1;
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					stamp = stamp + $urandom_range(0, 2 * step);
				end else if (pick < 80) begin
					stamp = stamp + $urandom_range(0, hold_us / 2 + 1);
				end else if (pick < 85) begin
					stamp = stamp - $urandom_range(1, 1000);
				end else if (pick < 90) begin
					wide = {$urandom, $urandom};
					stamp = wide[TW-1:0];
				end
				s.lvl = ($urandom_range(0, 9) == 0) ? !want_lvl : want_lvl;
				s.stamp = stamp;
				s.ack = 3'($urandom);
				offer_sample(s, 1'b0, '0);
			end
		end

		drain_reports();
		repeat (DRAIN_TAIL) @(posedge clk);
		$display("Checked %0d results from %0d samples over %0d threshold settings,",
			reports_seen, samples_sent, PHASE_COUNT + 2);
		$display("with bounces, wrapped and backward timestamps and a long output stall.");
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ button_debounce_hold_detect.f @@
+incdir+src
src/bdhd_pkg.sv
src/bdhd_core.sv
src/button_debounce_hold_detect.sv
test/tb_top.sv
